### rtl/rrfs_pkg.sv
package rrfs_pkg;

   typedef struct packed {
      logic       func;
      logic [7:0] run_length;
      logic       io_enable;
      logic [7:0] io_point;
      logic [4:0] io_length;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [6:0]  task_id;
      logic [1:0]  task_level;
      logic [7:0]  left_time;
      logic [6:0]  next_id;
      logic [6:0]  woken;
      logic        all_done;
      logic [31:0] clock_now;
   } rsp_type;

   localparam logic [2:0] EV_IDLE      = 3'd0;
   localparam logic [2:0] EV_RAN       = 3'd1;
   localparam logic [2:0] EV_BLOCKED   = 3'd2;
   localparam logic [2:0] EV_FINISHED  = 3'd3;
   localparam logic [2:0] EV_PREEMPTED = 3'd4;
   localparam logic [2:0] EV_CREATED   = 3'd5;
   localparam logic [2:0] EV_FAILED    = 3'd6;

   localparam logic CSR_FEEDBACK_MODE = 1'b0;
   localparam logic CSR_RR_SLICE      = 1'b1;

   // Per-task record held in the task memory.
   typedef struct packed {
      logic [8:0] time_left;
      logic [4:0] slice_count;
      logic [7:0] run_elapsed;
      logic       io_en;
      logic [7:0] io_pt;
      logic [4:0] io_len;
      logic [4:0] io_countdown;
      logic [2:0] level;
   } task_rec_type;

endpackage

### rtl/round_robin_feedback_scheduler.sv
// Transactions: one at a time; a tick walks the blocked list, and for each blocked entry
// reads the list (S_BRD), reads the task record (S_BREC, S_BRECW) and writes it back
// (S_BUPD), so the length of the blocked list sets the tick cost.
// Reset: synchronous, active high; clears control state, queues and counters. Memories
// are not cleared: a slot is only read after a create transaction wrote it.
module round_robin_feedback_scheduler #(
   parameter int TASKS      = 64,
   parameter int LEVELS     = 3,
   parameter int BASE_SLICE = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rrfs_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rrfs_pkg::rsp_type     rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [4:0]            csr_wdata
);
   import rrfs_pkg::*;

   localparam int SW = $clog2(TASKS);
   localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int CW = $clog2(TASKS + 1);

   // Sequencer states.
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_PICK   = 4'd1;  // read ready queue head
   localparam logic [3:0] S_RUNRD  = 4'd2;  // read running task record
   localparam logic [3:0] S_RUNUPD = 4'd3;  // update running task record
   localparam logic [3:0] S_BRD    = 4'd4;  // read blocked list entry
   localparam logic [3:0] S_BREC   = 4'd5;  // read blocked task record
   localparam logic [3:0] S_BUPD   = 4'd6;  // count down, maybe wake
   localparam logic [3:0] S_FIN    = 4'd7;  // decide fate of running task
   localparam logic [3:0] S_PICK2  = 4'd8;  // successor after preemption
   localparam logic [3:0] S_PICK2W = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;
   localparam logic [3:0] S_PICKW  = 4'd11;
   localparam logic [3:0] S_BRECW  = 4'd12;

   logic [3:0] state_ff, state_in;

   logic       mode_ff;
   logic [4:0] slice_ff;

   // Task record memory.
   task_rec_type tmem [TASKS];
   task_rec_type trd_ff;
   logic         twe;
   logic [SW-1:0] twa, tra;
   task_rec_type twd;

   // Ready queues: one memory, LEVELS regions of TASKS entries.
   logic [SW-1:0] qmem [LEVELS*TASKS];
   logic [SW-1:0] qrd_ff;
   logic          qwe;
   logic [$clog2(LEVELS*TASKS)-1:0] qwa, qra;
   logic [SW-1:0] qwd;
   logic [SW-1:0] qhead_ff [LEVELS];
   logic [CW-1:0] qcnt_ff  [LEVELS];

   // Blocked list, compacted in place during the walk.
   logic [SW-1:0] bmem [TASKS];
   logic [SW-1:0] brd_ff;
   logic          bwe;
   logic [SW-1:0] bwa, bra;
   logic [SW-1:0] bwd;
   logic [CW-1:0] bcnt_ff, bcnt_in;
   logic [CW-1:0] bidx_ff, bidx_in, bkept_ff, bkept_in;

   logic          run_v_ff, run_v_in;
   logic [SW-1:0] run_s_ff, run_s_in;
   logic [CW-1:0] used_ff;
   logic [31:0]   tick_ff;

   task_rec_type  cur_ff, cur_in;     // running task record being updated
   logic [SW-1:0] bs_ff, bs_in;       // blocked slot being visited
   logic [6:0]    woke_ff, woke_in;
   rsp_type       out_ff, out_in;
   logic          out_v_ff;

   // Ready queue picking.
   logic          any_ready;
   logic [LW-1:0] pick_lvl;
   always_comb begin
      any_ready = 1'b0;
      pick_lvl  = '0;
      for (int l = LEVELS - 1; l >= 0; l--) begin
         if (qcnt_ff[l] != '0) begin
            any_ready = 1'b1;
            pick_lvl  = LW'(l);
         end
      end
   end

   function automatic logic [$clog2(LEVELS*TASKS)-1:0] qaddr(
      input logic [LW-1:0] lvl, input logic [SW-1:0] pos);
      return ($clog2(LEVELS*TASKS))'(lvl) * ($clog2(LEVELS*TASKS))'(TASKS)
           + ($clog2(LEVELS*TASKS))'(pos);
   endfunction

   function automatic logic [SW-1:0] qtail(input logic [SW-1:0] hd, input logic [CW-1:0] cnt);
      logic [CW:0] t;
      t = (CW+1)'(hd) + (CW+1)'(cnt);
      if (t >= (CW+1)'(TASKS)) t = t - (CW+1)'(TASKS);
      return t[SW-1:0];
   endfunction

   function automatic logic [SW-1:0] qinc(input logic [SW-1:0] hd);
      return (hd == SW'(TASKS - 1)) ? '0 : hd + 1'b1;
   endfunction

   // Push and pop requests, applied in the clocked blocks.
   logic          push_v;
   logic [LW-1:0] push_l;
   logic [SW-1:0] push_s;
   logic          pop_v;

   // Decision for the running task after its tick.
   logic [8:0]  tl_dec;
   logic [4:0]  sc_inc;
   logic [7:0]  re_inc;
   logic        go_block, go_done, go_pre;
   logic [4:0]  slice_len;
   logic [2:0]  lvl_new;
   always_comb begin
      tl_dec   = cur_ff.time_left;
      sc_inc   = cur_ff.slice_count;
      re_inc   = cur_ff.run_elapsed;
      slice_len = mode_ff ? 5'(BASE_SLICE << cur_ff.level) : slice_ff;
      go_block = cur_ff.io_en && (re_inc == cur_ff.io_pt);
      go_done  = !go_block && (tl_dec[8] || tl_dec == '0);
      go_pre   = !go_block && !go_done && ({1'b0, sc_inc} >= {1'b0, slice_len}) ;
      lvl_new  = (go_pre && mode_ff && (32'(cur_ff.level) + 1 < LEVELS))
                 ? cur_ff.level + 3'd1 : cur_ff.level;
   end

   logic [CW+8:0] busy_sum;
   always_comb begin
      busy_sum = (CW+9)'(bcnt_ff) + (CW+9)'(run_v_ff);
      for (int l = 0; l < LEVELS; l++) busy_sum = busy_sum + (CW+9)'(qcnt_ff[l]);
   end

   assign req_ready = (state_ff == S_IDLE) && !out_v_ff;
   assign csr_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   // Next-state logic and memory port control.
   always_comb begin
      state_in = state_ff;
      run_v_in = run_v_ff;
      run_s_in = run_s_ff;
      bcnt_in  = bcnt_ff;
      bidx_in  = bidx_ff;
      bkept_in = bkept_ff;
      cur_in   = cur_ff;
      bs_in    = bs_ff;
      woke_in  = woke_ff;
      out_in   = out_ff;
      twe = 1'b0; twa = '0; twd = cur_ff; tra = run_s_ff;
      qra = qaddr(pick_lvl, qhead_ff[pick_lvl]);
      bwe = 1'b0; bwa = '0; bwd = '0; bra = bidx_ff[SW-1:0];
      push_v = 1'b0; push_l = '0; push_s = '0; pop_v = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               out_in = '0;
               woke_in = '0;
               if (!req_data.func) begin
                  out_in.clock_now = tick_ff;
                  if (used_ff >= CW'(TASKS)) begin
                     out_in.event_res = EV_FAILED;
                  end else begin
                     twe = 1'b1;
                     twa = used_ff[SW-1:0];
                     twd = '0;
                     twd.time_left = {1'b0, req_data.run_length};
                     twd.io_en  = req_data.io_enable;
                     twd.io_pt  = req_data.io_point;
                     twd.io_len = req_data.io_length;
                     push_v = 1'b1; push_l = '0; push_s = used_ff[SW-1:0];
                     out_in.event_res = EV_CREATED;
                     out_in.task_id   = 7'(used_ff + 1'b1);
                  end
                  state_in = S_DONE;
               end else begin
                  out_in.clock_now = tick_ff + 32'd1;
                  bidx_in  = '0;
                  bkept_in = '0;
                  state_in = (!run_v_ff && any_ready) ? S_PICK
                           : (run_v_ff ? S_RUNRD : S_BRD);
               end
            end
         end
         S_PICK: begin
            pop_v = 1'b1;
            state_in = S_PICKW;
         end
         S_PICKW: begin
            run_v_in = 1'b1;
            run_s_in = qrd_ff;
            state_in = S_RUNRD;
         end
         S_RUNRD: begin
            tra = run_s_ff;
            state_in = S_RUNUPD;
         end
         S_RUNUPD: begin
            cur_in = trd_ff;
            cur_in.time_left   = trd_ff.time_left - 9'd1;
            cur_in.slice_count = trd_ff.slice_count + 5'd1;
            cur_in.run_elapsed = trd_ff.run_elapsed + 8'd1;
            state_in = S_BRD;
         end
         S_BRD: begin
            if (bidx_ff >= bcnt_ff) begin
               bcnt_in = bkept_ff;
               state_in = S_FIN;
            end else begin
               bra = bidx_ff[SW-1:0];
               state_in = S_BREC;
            end
         end
         S_BREC: begin
            bs_in = brd_ff;
            tra = brd_ff;
            state_in = S_BRECW;
         end
         S_BRECW: begin
            // Keep the blocked task's record on the read port for the update cycle.
            tra = bs_ff;
            state_in = S_BUPD;
         end
         S_BUPD: begin
            twe = 1'b1; twa = bs_ff; twd = trd_ff;
            if (trd_ff.io_countdown != '0) twd.io_countdown = trd_ff.io_countdown - 5'd1;
            if (trd_ff.io_countdown == 5'd1) begin
               push_v = 1'b1;
               push_l = mode_ff ? LW'(trd_ff.level) : '0;
               push_s = bs_ff;
               woke_in = woke_ff + 7'd1;
            end else begin
               bwe = 1'b1; bwa = bkept_ff[SW-1:0]; bwd = bs_ff;
               bkept_in = bkept_ff + 1'b1;
            end
            bidx_in = bidx_ff + 1'b1;
            state_in = S_BRD;
         end
         S_FIN: begin
            out_in.woken = woke_ff;
            if (!run_v_ff) begin
               out_in.event_res = EV_IDLE;
               state_in = S_DONE;
            end else begin
               twe = 1'b1; twa = run_s_ff; twd = cur_ff;
               out_in.task_id = 7'(32'(run_s_ff) + 1);
               out_in.next_id = '0;
               out_in.task_level = 2'(lvl_new);
               out_in.left_time = (tl_dec[8] || tl_dec == '0) ? 8'd0 : tl_dec[7:0];
               state_in = S_DONE;
               if (go_block) begin
                  twd.io_countdown = cur_ff.io_len;
                  bwe = 1'b1; bwa = bcnt_ff[SW-1:0]; bwd = run_s_ff;
                  bcnt_in = bcnt_ff + 1'b1;
                  run_v_in = 1'b0;
                  out_in.event_res = EV_BLOCKED;
               end else if (go_done) begin
                  twd.time_left = '0;
                  run_v_in = 1'b0;
                  out_in.event_res = EV_FINISHED;
               end else if (go_pre) begin
                  twd.slice_count = '0;
                  twd.level = lvl_new;
                  run_v_in = 1'b0;
                  push_v = 1'b1;
                  push_l = mode_ff ? LW'(lvl_new) : '0;
                  push_s = run_s_ff;
                  out_in.event_res = EV_PREEMPTED;
                  state_in = S_PICK2;
               end else begin
                  out_in.event_res = EV_RAN;
               end
            end
         end
         S_PICK2: begin
            if (any_ready) begin
               pop_v = 1'b1;
               state_in = S_PICK2W;
            end else begin
               state_in = S_DONE;
            end
         end
         S_PICK2W: begin
            // Successor gets a fresh slice; its record is rewritten on its next tick.
            run_v_in = 1'b1;
            run_s_in = qrd_ff;
            out_in.next_id = 7'(32'(qrd_ff) + 1);
            state_in = S_DONE;
         end
         S_DONE: begin
            out_in.all_done = (busy_sum == '0);
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Slice count restarts at dispatch: clear it when a task is picked.
   logic          clr_slice;
   assign clr_slice = (state_ff == S_PICKW) || (state_ff == S_PICK2W);

   always_ff @(posedge clock) begin
      trd_ff <= tmem[tra];
      if (twe) tmem[twa] <= twd;
      else if (clr_slice) tmem[qrd_ff].slice_count <= '0;
      qrd_ff <= qmem[qra];
      if (qwe) qmem[qwa] <= qwd;
      brd_ff <= bmem[bra];
      if (bwe) bmem[bwa] <= bwd;
   end

   assign qwe = push_v;
   assign qwa = qaddr(push_l, qtail(qhead_ff[push_l], qcnt_ff[push_l]));
   assign qwd = push_s;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         mode_ff    <= 1'b0;
         slice_ff   <= 5'd2;
         run_v_ff   <= 1'b0;
         run_s_ff   <= '0;
         used_ff    <= '0;
         tick_ff    <= '0;
         bcnt_ff    <= '0;
         bidx_ff    <= '0;
         bkept_ff   <= '0;
         out_v_ff   <= 1'b0;
         woke_ff    <= '0;
         for (int l = 0; l < LEVELS; l++) begin
            qhead_ff[l] <= '0;
            qcnt_ff[l]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         run_v_ff <= run_v_in;
         run_s_ff <= run_s_in;
         bcnt_ff  <= bcnt_in;
         bidx_ff  <= bidx_in;
         bkept_ff <= bkept_in;
         woke_ff  <= woke_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_FEEDBACK_MODE: mode_ff  <= csr_wdata[0];
               CSR_RR_SLICE:      slice_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (state_ff == S_IDLE && req_valid && req_ready) begin
            if (req_data.func) tick_ff <= tick_ff + 32'd1;
            else if (used_ff < CW'(TASKS)) used_ff <= used_ff + 1'b1;
         end
         for (int l = 0; l < LEVELS; l++) begin
            if (push_v && push_l == LW'(l) && !(pop_v && pick_lvl == LW'(l)))
               qcnt_ff[l] <= qcnt_ff[l] + 1'b1;
            else if (pop_v && pick_lvl == LW'(l) && !(push_v && push_l == LW'(l)))
               qcnt_ff[l] <= qcnt_ff[l] - 1'b1;
            if (pop_v && pick_lvl == LW'(l)) qhead_ff[l] <= qinc(qhead_ff[l]);
         end
         if (state_ff == S_DONE) out_v_ff <= 1'b1;
         else if (rsp_ready) out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      bs_ff  <= bs_in;
      out_ff <= out_in;
   end

   // A result is only raised once the sequencer has finished its transaction.
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_v_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside completion");
   // The blocked walk never runs past the list.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_BREC |-> bidx_ff < bcnt_ff)
      else $error("blocked walk overran");
   // The kept count never passes the visited count.
   assert property (@(posedge clock) disable iff (reset)
      bkept_ff <= bidx_ff || state_ff == S_IDLE)
      else $error("blocked compaction inconsistent");

endmodule

### dv/round_robin_feedback_scheduler_test.sv
module round_robin_feedback_scheduler_test;
   import rrfs_pkg::*;

   localparam int NTASK = 64;
   localparam int NLVL = 3;
   localparam int LIMIT_CYCLES = 2000000;

   // Slot states of the scheduler's task table.
   typedef enum logic [2:0] {
      SLOT_FREE, SLOT_READY, SLOT_RUNNING, SLOT_BLOCKED, SLOT_DONE
   } slot_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic csr_index = 1'b0;
   logic [4:0] csr_wdata = '0;

   round_robin_feedback_scheduler uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // Shadow copy of the scheduler state, kept by the predictor below.
   logic mode_fb;
   logic [4:0] slice_len;
   slot_state_type slot_st[NTASK];
   int time_rem[NTASK];
   int slice_spent[NTASK];
   int ran_ticks[NTASK];
   logic plan_io[NTASK];
   int plan_pt[NTASK];
   int plan_len[NTASK];
   int io_wait[NTASK];
   int lvl_of[NTASK];
   int ready_q[NLVL][$];
   int blocked_q[$];
   int cur_slot;
   int used_slots;
   logic [31:0] ticks;

   rsp_type expected_rsps[$];
   int fail_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;

   function automatic int take_ready();
      int s;
      for (int l = 0; l < NLVL; l++) begin
         if (ready_q[l].size() > 0) begin
            s = ready_q[l].pop_front();
            return s;
         end
      end
      return NTASK;
   endfunction

   function automatic void dispatch(int s);
      slot_st[s] = SLOT_RUNNING;
      slice_spent[s] = 0;
      cur_slot = s;
   endfunction

   // Walk the blocked list in order, counting down I/O and waking tasks.
   function automatic int wake_blocked();
      int kept[$];
      int n;
      int s;
      n = 0;
      foreach (blocked_q[i]) begin
         s = blocked_q[i];
         if (io_wait[s] > 0) begin
            io_wait[s]--;
            if (io_wait[s] == 0) begin
               slot_st[s] = SLOT_READY;
               ready_q[mode_fb ? lvl_of[s] : 0].push_back(s);
               n++;
               continue;
            end
         end
         kept.push_back(s);
      end
      blocked_q = kept;
      return n;
   endfunction

   function automatic void shadow_reset();
      mode_fb = 1'b0;
      slice_len = 5'd2;
      for (int i = 0; i < NTASK; i++) slot_st[i] = SLOT_FREE;
      for (int l = 0; l < NLVL; l++) ready_q[l].delete();
      blocked_q.delete();
      cur_slot = NTASK;
      used_slots = 0;
      ticks = '0;
   endfunction

   function automatic rsp_type schedule_step(req_type r);
      rsp_type o;
      int s;
      int n;
      int sl;
      int pending;
      o = '0;
      if (r.func == 1'b0) begin
         if (used_slots >= NTASK) begin
            o.event_res = EV_FAILED;
         end else begin
            s = used_slots++;
            slot_st[s] = SLOT_READY;
            time_rem[s] = r.run_length;
            slice_spent[s] = 0;
            ran_ticks[s] = 0;
            plan_io[s] = r.io_enable;
            plan_pt[s] = r.io_point;
            plan_len[s] = r.io_length;
            io_wait[s] = 0;
            lvl_of[s] = 0;
            ready_q[0].push_back(s);
            o.event_res = EV_CREATED;
            o.task_id = 7'(s + 1);
         end
      end else begin
         if (cur_slot >= NTASK) begin
            s = take_ready();
            if (s < NTASK) dispatch(s);
         end
         ticks++;
         if (cur_slot >= NTASK) begin
            o.woken = 7'(wake_blocked());
            o.event_res = EV_IDLE;
         end else begin
            s = cur_slot;
            slice_spent[s]++;
            time_rem[s]--;
            ran_ticks[s]++;
            o.woken = 7'(wake_blocked());
            o.task_id = 7'(s + 1);
            sl = mode_fb ? (2 << lvl_of[s]) : slice_len;
            if (plan_io[s] && ran_ticks[s] == plan_pt[s]) begin
               slot_st[s] = SLOT_BLOCKED;
               io_wait[s] = plan_len[s];
               blocked_q.push_back(s);
               cur_slot = NTASK;
               o.event_res = EV_BLOCKED;
            end else if (time_rem[s] <= 0) begin
               slot_st[s] = SLOT_DONE;
               time_rem[s] = 0;
               cur_slot = NTASK;
               o.event_res = EV_FINISHED;
            end else if (slice_spent[s] >= sl) begin
               slot_st[s] = SLOT_READY;
               slice_spent[s] = 0;
               if (mode_fb && lvl_of[s] + 1 < NLVL) lvl_of[s]++;
               cur_slot = NTASK;
               ready_q[mode_fb ? lvl_of[s] : 0].push_back(s);
               n = take_ready();
               if (n < NTASK) begin
                  dispatch(n);
                  o.next_id = 7'(n + 1);
               end
               o.event_res = EV_PREEMPTED;
            end else begin
               o.event_res = EV_RAN;
            end
            o.task_level = 2'(lvl_of[s]);
            o.left_time = time_rem[s] > 255 ? 8'd255
                        : (time_rem[s] <= 0 ? 8'd0 : 8'(time_rem[s]));
         end
      end
      pending = blocked_q.size() + (cur_slot < NTASK ? 1 : 0);
      for (int l = 0; l < NLVL; l++) pending += ready_q[l].size();
      o.all_done = (pending == 0);
      o.clock_now = ticks;
      return o;
   endfunction

   // Result checker: every accepted result is matched against the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               fail_count++;
            end else begin
               rsp_type e;
               e = expected_rsps.pop_front();
               if (rsp_data !== e) begin
                  $display("%0t: result mismatch expected %p actual %p", $time, e, rsp_data);
                  fail_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog on the total cycle count.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("round_robin_feedback_scheduler_test: FAIL");
         $finish;
      end
   end

   // Send one transaction; the prediction is recorded when it is accepted.
   // The block cannot take another transaction in the cycle after acceptance,
   // so the sender steps past that cycle after dropping valid.
   task automatic send_req(req_type r);
      while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      expected_rsps.push_back(schedule_step(r));
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_rsps();
      while (expected_rsps.size() != 0) @(posedge clock);
      // The block is idle once the last result is taken; leave a quiet gap between phases.
      repeat (200) @(posedge clock);
   endtask

   // Register writes happen only with the block idle.
   task automatic write_csr(logic idx, logic [4:0] val);
      drain_rsps();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_FEEDBACK_MODE) mode_fb = val[0];
      else slice_len = val;
   endtask

   function automatic req_type make_create(int len, logic io, int pt, int iol);
      req_type r;
      r.func = 1'b0;
      r.run_length = 8'(len);
      r.io_enable = io;
      r.io_point = 8'(pt);
      r.io_length = 5'(iol);
      return r;
   endfunction

   function automatic req_type make_tick();
      req_type r;
      r = '0;
      r.func = 1'b1;
      r.run_length = 8'($urandom);
      r.io_enable = 1'($urandom);
      r.io_point = 8'($urandom);
      r.io_length = 5'($urandom);
      return r;
   endfunction

   // Directed: an idle tick, extremes of fields, I/O at the run length.
   task automatic test_directed();
      send_req(make_tick());
      send_req(make_create(255, 1'b1, 255, 31));
      send_req(make_create(1, 1'b0, 1, 1));
      send_req(make_create(3, 1'b1, 3, 1));
      send_req(make_create(5, 1'b1, 1, 31));
      send_req(make_create(170, 1'b0, 85, 21));
      repeat (20) send_req(make_tick());
   endtask

   // Random tasks under a given setting; ticks dominate the mix.
   task automatic test_random(int count);
      req_type r;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 12) begin
            r = make_create($urandom_range(9) == 0 ? $urandom_range(1, 255)
                            : $urandom_range(1, 12), 1'($urandom),
                            $urandom_range(3) == 0 ? $urandom_range(1, 255)
                            : $urandom_range(1, 8), $urandom_range(1, 31));
            send_req(r);
         end else begin
            send_req(make_tick());
         end
      end
   endtask

   // Pressure: sender holds off until every result has come back.
   task automatic test_pause();
      drain_rsps();
      send_req(make_tick());
   endtask

   initial begin
      shadow_reset();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_csr(CSR_RR_SLICE, 5'd1);
      test_random(300);
      test_pause();
      send_idle_pct = 68;
      write_csr(CSR_FEEDBACK_MODE, 5'd1);
      test_random(400);
      recv_stall_pct = 68;
      send_idle_pct = 0;
      write_csr(CSR_RR_SLICE, 5'd20);
      write_csr(CSR_FEEDBACK_MODE, 5'd0);
      test_random(400);
      send_idle_pct = 13;
      recv_stall_pct = 13;
      write_csr(CSR_FEEDBACK_MODE, 5'd1);
      test_random(400);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      write_csr(CSR_FEEDBACK_MODE, 5'd0);
      write_csr(CSR_RR_SLICE, 5'd7);
      test_random(400);
      drain_rsps();
      if (fail_count == 0) begin
         $display("round_robin_feedback_scheduler_test: PASS");
      end else begin
         $display("round_robin_feedback_scheduler_test: FAIL");
      end
      $finish;
   end
endmodule
